/* sv/sit_pkg.sv */
// sit_pkg: shared types, codes and saturation helpers for the sorted interval table
// no dependencies; used by sit_ctrl, sit_datapath, sorted_interval_table_core and the testbench
`default_nettype none

package sit_pkg;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REPAIR = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam int CNT_W = 7;
  localparam int POS_W = 6;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic [15:0]        node_id;
    logic               move_overlapping;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] entry_start;
    logic signed [31:0] entry_end;
    logic [15:0]        entry_id;
    logic [POS_W-1:0]   position;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] ent_start;
    logic signed [31:0] ent_end;
    logic [15:0]        ent_id;
  } entry_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_I,
    OP_INS_SCAN,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_INS_WR,
    OP_SORT_INIT,
    OP_SORT_KEY,
    OP_SORT_RDJ,
    OP_SORT_SHIFT,
    OP_SORT_PLACE,
    OP_WALK_INIT,
    OP_WALK_FIRST,
    OP_WALK_FIX,
    OP_WALK_NEXT,
    OP_WALK_MOVE,
    OP_DEL_STEP,
    OP_DEL_END,
    OP_FIND_STEP,
    OP_FIND_MISS,
    OP_QUERY_STEP,
    OP_QUERY_END,
    OP_OUT_RD,
    OP_EMIT_ENTRY,
    OP_EMIT_FULL,
    OP_EMIT_PLAIN
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] command;
    logic       move;
    logic       full;
    logic       n_zero;
    logic       i_lt_n;
    logic       i_gt_pos;
    logic       j_zero;
    logic       sort_gt;
    logic       walk_more;
    logic       walk_move;
    logic       hit;
  } dp_stat_t;

  // saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33] != v[32]) || (v[33] != v[31])) r = v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/sorted_interval_table_core.sv */
// sorted_interval_table_core: top level of the sorted interval table
// depends on sit_pkg, sit_ctrl and sit_datapath
//
// Usage: a request (command, range, id, repair flag) is taken on a rising edge
// with start high and busy low. busy stays high until the last result of that
// request has been driven. Each result sits on result for exactly one cycle,
// marked by strobe; the receiver cannot stall, so results are never held.
// A range query gives one result per matching entry, last marking the final
// one; every other command gives a single result.
// Commands work over one memory port of registered read:
//   find, query, delete: one read and one compare per entry
//   insert: a scan for the slot, a shift to open a gap there, then the write
//   repair, also after an insert with the flag: insertion sort by start,
//   then a walk over the entries that fixes negative starts and overlaps
// Reset (rst, synchronous) empties the table and returns to idle at once;
// stored entries are not cleared and are never used before being written.

`default_nettype none

module sorted_interval_table_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire sit_pkg::req_t  request,
  output logic                busy,
  output sit_pkg::rsp_t       result,
  output logic                strobe
);

  sit_pkg::dp_op_t   op;
  sit_pkg::dp_stat_t stat;

  // sequencer
  sit_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  // table storage and arithmetic
  sit_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .request (request),
    .stat    (stat),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

`default_nettype wire

/* sv/sit_ctrl.sv */
// sit_ctrl: command sequencer for the sorted interval table
// depends on sit_pkg; drives sit_datapath through micro-operations
`default_nettype none

module sit_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire sit_pkg::dp_stat_t stat,
  output sit_pkg::dp_op_t        op,
  output logic                   busy
);

  typedef enum logic [23:0] {
    S_IDLE        = 24'h000001,
    S_DISPATCH    = 24'h000002,
    S_INS_RD      = 24'h000004,
    S_INS_CMP     = 24'h000008,
    S_SHIFT_RD    = 24'h000010,
    S_SHIFT_WR    = 24'h000020,
    S_INS_WR      = 24'h000040,
    S_SORT_START  = 24'h000080,
    S_SORT_KEY_RD = 24'h000100,
    S_SORT_KEY    = 24'h000200,
    S_SORT_J      = 24'h000400,
    S_SORT_CMP    = 24'h000800,
    S_WALK_FIRST  = 24'h001000,
    S_WALK_FIX    = 24'h002000,
    S_WALK_NEXT   = 24'h004000,
    S_WALK_MOVE   = 24'h008000,
    S_FINISH      = 24'h010000,
    S_OUT_EMIT    = 24'h020000,
    S_DEL_RD      = 24'h040000,
    S_DEL_CMP     = 24'h080000,
    S_FIND_RD     = 24'h100000,
    S_FIND_CMP    = 24'h200000,
    S_Q_RD        = 24'h400000,
    S_Q_CMP       = 24'h800000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  // next state and operation
  always_comb begin
    state_next = state;
    op = sit_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op = sit_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.command)
          sit_pkg::CMD_INSERT: begin
            if (stat.full) begin
              op = sit_pkg::OP_EMIT_FULL;
              state_next = S_IDLE;
            end else state_next = S_INS_RD;
          end
          sit_pkg::CMD_REPAIR: state_next = S_SORT_START;
          sit_pkg::CMD_DELETE: state_next = S_DEL_RD;
          sit_pkg::CMD_FIND:   state_next = S_FIND_RD;
          sit_pkg::CMD_QUERY:  state_next = S_Q_RD;
          default: begin
            op = sit_pkg::OP_EMIT_PLAIN;
            state_next = S_IDLE;
          end
        endcase
      end
      // find the insertion slot
      S_INS_RD: begin
        if (stat.i_lt_n) begin
          op = sit_pkg::OP_RD_I;
          state_next = S_INS_CMP;
        end else state_next = S_SHIFT_RD;
      end
      S_INS_CMP: begin
        op = sit_pkg::OP_INS_SCAN;
        state_next = S_INS_RD;
      end
      // open a gap at the slot
      S_SHIFT_RD: begin
        if (stat.i_gt_pos) begin
          op = sit_pkg::OP_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end else state_next = S_INS_WR;
      end
      S_SHIFT_WR: begin
        op = sit_pkg::OP_SHIFT_WR;
        state_next = S_SHIFT_RD;
      end
      S_INS_WR: begin
        op = sit_pkg::OP_INS_WR;
        state_next = stat.move ? S_SORT_START : S_FINISH;
      end
      // stable insertion sort by start
      S_SORT_START: begin
        op = sit_pkg::OP_SORT_INIT;
        state_next = S_SORT_KEY_RD;
      end
      S_SORT_KEY_RD: begin
        if (stat.i_lt_n) begin
          op = sit_pkg::OP_RD_I;
          state_next = S_SORT_KEY;
        end else if (stat.n_zero) begin
          state_next = S_FINISH;
        end else begin
          op = sit_pkg::OP_WALK_INIT;
          state_next = S_WALK_FIRST;
        end
      end
      S_SORT_KEY: begin
        op = sit_pkg::OP_SORT_KEY;
        state_next = S_SORT_J;
      end
      S_SORT_J: begin
        if (stat.j_zero) begin
          op = sit_pkg::OP_SORT_PLACE;
          state_next = S_SORT_KEY_RD;
        end else begin
          op = sit_pkg::OP_SORT_RDJ;
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat.sort_gt) begin
          op = sit_pkg::OP_SORT_SHIFT;
          state_next = S_SORT_J;
        end else begin
          op = sit_pkg::OP_SORT_PLACE;
          state_next = S_SORT_KEY_RD;
        end
      end
      // overlap walk
      S_WALK_FIRST: begin
        op = sit_pkg::OP_WALK_FIRST;
        state_next = S_WALK_FIX;
      end
      S_WALK_FIX: begin
        op = sit_pkg::OP_WALK_FIX;
        state_next = stat.walk_more ? S_WALK_NEXT : S_FINISH;
      end
      S_WALK_NEXT: begin
        op = sit_pkg::OP_WALK_NEXT;
        state_next = stat.walk_move ? S_WALK_MOVE : S_WALK_FIX;
      end
      S_WALK_MOVE: begin
        op = sit_pkg::OP_WALK_MOVE;
        state_next = S_WALK_FIX;
      end
      // report after insert or repair
      S_FINISH: begin
        if (stat.command == sit_pkg::CMD_INSERT) begin
          op = sit_pkg::OP_OUT_RD;
          state_next = S_OUT_EMIT;
        end else begin
          op = sit_pkg::OP_EMIT_PLAIN;
          state_next = S_IDLE;
        end
      end
      S_OUT_EMIT: begin
        op = sit_pkg::OP_EMIT_ENTRY;
        state_next = S_IDLE;
      end
      // delete range with compaction
      S_DEL_RD: begin
        if (stat.i_lt_n) begin
          op = sit_pkg::OP_RD_I;
          state_next = S_DEL_CMP;
        end else begin
          op = sit_pkg::OP_DEL_END;
          state_next = S_IDLE;
        end
      end
      S_DEL_CMP: begin
        op = sit_pkg::OP_DEL_STEP;
        state_next = S_DEL_RD;
      end
      // find by id
      S_FIND_RD: begin
        if (stat.i_lt_n) begin
          op = sit_pkg::OP_RD_I;
          state_next = S_FIND_CMP;
        end else begin
          op = sit_pkg::OP_FIND_MISS;
          state_next = S_IDLE;
        end
      end
      S_FIND_CMP: begin
        op = sit_pkg::OP_FIND_STEP;
        state_next = stat.hit ? S_IDLE : S_FIND_RD;
      end
      // range query
      S_Q_RD: begin
        if (stat.i_lt_n) begin
          op = sit_pkg::OP_RD_I;
          state_next = S_Q_CMP;
        end else begin
          op = sit_pkg::OP_QUERY_END;
          state_next = S_IDLE;
        end
      end
      S_Q_CMP: begin
        op = sit_pkg::OP_QUERY_STEP;
        state_next = S_Q_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* sv/sit_datapath.sv */
// sit_datapath: interval memory, counters and arithmetic for the sorted interval table
// depends on sit_pkg; controlled by sit_ctrl
`default_nettype none

module sit_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sit_pkg::dp_op_t op,
  input  wire sit_pkg::req_t   request,
  output sit_pkg::dp_stat_t    stat,
  output sit_pkg::rsp_t        result,
  output logic                 strobe
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] ONE = CW'(1);

  sit_pkg::entry_t mem [CAPACITY];

  sit_pkg::req_t   req;
  sit_pkg::entry_t rd, key, cur, pend;
  logic [CW-1:0]   n, i, j, pos, track, kept;
  logic [AW-1:0]   pend_pos;
  logic            pend_valid, tracked;
  logic signed [32:0] dur;

  logic [CW-1:0]   raddr_full;
  logic [CW-1:0]   waddr_full;
  logic            we;
  sit_pkg::entry_t wdata;
  sit_pkg::entry_t fix_c;
  sit_pkg::entry_t new_e;
  logic            in_range;
  logic            emit;
  sit_pkg::rsp_t   emit_d;
  logic signed [31:0] moved_start;
  logic signed [31:0] moved_end;

  // memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr_full[AW-1:0]] <= wdata;
    rd <= mem[raddr_full[AW-1:0]];
  end

  // comparisons and arithmetic
  always_comb begin
    in_range = (rd.ent_start >= req.range_start) && (rd.ent_end <= req.range_end);
    fix_c = cur;
    if (cur.ent_start < 0) begin
      fix_c.ent_start = '0;
      fix_c.ent_end = sit_pkg::sat33(33'(cur.ent_end) - 33'(cur.ent_start));
    end
    moved_start = sit_pkg::sat33(33'(cur.ent_end) + 33'sd1);
    moved_end = sit_pkg::sat34(34'(cur.ent_start) + 34'(dur));
    new_e.ent_start = req.range_start;
    new_e.ent_end = req.range_end;
    new_e.ent_id = req.node_id;
  end

  // status to the controller
  always_comb begin
    stat.command   = req.command;
    stat.move      = req.move_overlapping;
    stat.full      = (n >= CW'(CAPACITY));
    stat.n_zero    = (n == '0);
    stat.i_lt_n    = (i < n);
    stat.i_gt_pos  = (i > pos);
    stat.j_zero    = (j == '0);
    stat.sort_gt   = (rd.ent_start > key.ent_start);
    stat.walk_more = ({1'b0, i} + {1'b0, ONE}) < {1'b0, n};
    stat.walk_move = (rd.ent_start < cur.ent_end);
    stat.hit       = (rd.ent_id == req.node_id);
  end

  // read address and write port
  always_comb begin
    raddr_full = i;
    we = 1'b0;
    waddr_full = i;
    wdata = rd;
    case (op)
      sit_pkg::OP_SHIFT_RD:  raddr_full = i - ONE;
      sit_pkg::OP_SORT_RDJ:  raddr_full = j - ONE;
      sit_pkg::OP_WALK_INIT: raddr_full = '0;
      sit_pkg::OP_WALK_FIX: begin
        raddr_full = i + ONE;
        we = 1'b1;
        wdata = fix_c;
      end
      sit_pkg::OP_OUT_RD:    raddr_full = track;
      sit_pkg::OP_SHIFT_WR:  we = 1'b1;
      sit_pkg::OP_SORT_SHIFT: begin
        we = 1'b1;
        waddr_full = j;
      end
      sit_pkg::OP_SORT_PLACE: begin
        we = 1'b1;
        waddr_full = j;
        wdata = key;
      end
      sit_pkg::OP_INS_WR: begin
        we = 1'b1;
        waddr_full = pos;
        wdata = new_e;
      end
      sit_pkg::OP_DEL_STEP: begin
        we = !in_range && (kept != i);
        waddr_full = kept;
      end
      default: ;
    endcase
  end

  // result selection
  always_comb begin
    emit = 1'b0;
    emit_d = '0;
    emit_d.count = sit_pkg::CNT_W'(n);
    emit_d.last = 1'b1;
    case (op)
      sit_pkg::OP_EMIT_FULL: begin
        emit = 1'b1;
        emit_d.status = sit_pkg::ST_FULL;
      end
      sit_pkg::OP_EMIT_PLAIN: begin
        emit = 1'b1;
        emit_d.status = sit_pkg::ST_OK;
      end
      sit_pkg::OP_EMIT_ENTRY: begin
        emit = 1'b1;
        emit_d.status = sit_pkg::ST_OK;
        emit_d.entry_start = rd.ent_start;
        emit_d.entry_end = rd.ent_end;
        emit_d.entry_id = rd.ent_id;
        emit_d.position = sit_pkg::POS_W'(track[AW-1:0]);
      end
      sit_pkg::OP_DEL_END: begin
        emit = 1'b1;
        emit_d.status = (n != kept) ? sit_pkg::ST_OK : sit_pkg::ST_NONE;
        emit_d.count = sit_pkg::CNT_W'(n - kept);
      end
      sit_pkg::OP_FIND_STEP: begin
        emit = stat.hit;
        emit_d.status = sit_pkg::ST_OK;
        emit_d.entry_start = rd.ent_start;
        emit_d.entry_end = rd.ent_end;
        emit_d.entry_id = rd.ent_id;
        emit_d.position = sit_pkg::POS_W'(i[AW-1:0]);
      end
      sit_pkg::OP_FIND_MISS: begin
        emit = 1'b1;
        emit_d.status = sit_pkg::ST_NONE;
      end
      sit_pkg::OP_QUERY_STEP, sit_pkg::OP_QUERY_END: begin
        emit = pend_valid && (in_range || (op == sit_pkg::OP_QUERY_END));
        emit_d.status = sit_pkg::ST_OK;
        emit_d.entry_start = pend.ent_start;
        emit_d.entry_end = pend.ent_end;
        emit_d.entry_id = pend.ent_id;
        emit_d.position = sit_pkg::POS_W'(pend_pos);
        emit_d.last = (op == sit_pkg::OP_QUERY_END);
        if ((op == sit_pkg::OP_QUERY_END) && !pend_valid) begin
          emit = 1'b1;
          emit_d = '0;
          emit_d.status = sit_pkg::ST_NONE;
          emit_d.count = sit_pkg::CNT_W'(n);
          emit_d.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= emit;
    if (emit) result <= emit_d;
  end

  // stored count
  always_ff @(posedge clk) begin
    if (rst) n <= '0;
    else if (op == sit_pkg::OP_INS_WR) n <= n + ONE;
    else if (op == sit_pkg::OP_DEL_END) n <= kept;
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      sit_pkg::OP_LOAD: begin
        req <= request;
        i <= '0;
        pos <= '0;
        kept <= '0;
        pend_valid <= 1'b0;
        track <= CW'(CAPACITY);
      end
      sit_pkg::OP_INS_SCAN: begin
        if (rd.ent_start <= req.range_start) pos <= i + ONE;
        i <= i + ONE;
      end
      sit_pkg::OP_SHIFT_WR: i <= i - ONE;
      sit_pkg::OP_INS_WR:   track <= pos;
      sit_pkg::OP_SORT_INIT: i <= ONE;
      sit_pkg::OP_SORT_KEY: begin
        key <= rd;
        j <= i;
        tracked <= (track == i);
      end
      sit_pkg::OP_SORT_SHIFT: begin
        if (track == (j - ONE)) track <= j;
        j <= j - ONE;
      end
      sit_pkg::OP_SORT_PLACE: begin
        if (tracked) track <= j;
        i <= i + ONE;
      end
      sit_pkg::OP_WALK_INIT:  i <= '0;
      sit_pkg::OP_WALK_FIRST: cur <= rd;
      sit_pkg::OP_WALK_FIX:   cur <= fix_c;
      sit_pkg::OP_WALK_NEXT: begin
        if (stat.walk_move) begin
          cur.ent_start <= moved_start;
          cur.ent_end <= rd.ent_end;
          cur.ent_id <= rd.ent_id;
          dur <= 33'(rd.ent_end) - 33'(rd.ent_start);
        end else begin
          cur <= rd;
          i <= i + ONE;
        end
      end
      sit_pkg::OP_WALK_MOVE: begin
        cur.ent_end <= moved_end;
        i <= i + ONE;
      end
      sit_pkg::OP_DEL_STEP: begin
        if (!in_range) kept <= kept + ONE;
        i <= i + ONE;
      end
      sit_pkg::OP_FIND_STEP: i <= i + ONE;
      sit_pkg::OP_QUERY_STEP: begin
        if (in_range) begin
          pend <= rd;
          pend_pos <= i[AW-1:0];
          pend_valid <= 1'b1;
        end
        i <= i + ONE;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// testbench: self-checking bench for sorted_interval_table_core
// depends on sit_pkg and the core; runs a directed table, a fill to full, then random requests
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 64;

  logic           clk;
  logic           rst;
  logic           start;
  sit_pkg::req_t  request;
  logic           busy;
  sit_pkg::rsp_t  result;
  logic           strobe;

  sorted_interval_table_core #(.CAPACITY(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .result(result), .strobe(strobe)
  );

  // shadow copy of the table contents
  logic signed [31:0] shadow_start [DEPTH];
  logic signed [31:0] shadow_end [DEPTH];
  logic [15:0]        shadow_id [DEPTH];
  int                 shadow_count;

  sit_pkg::rsp_t pending_rsp [$];
  int            mismatches;

  // directed table row
  typedef struct {
    sit_pkg::req_t req;
    bit            typed;
    sit_pkg::rsp_t rsp;
  } stim_row_t;

  stim_row_t stim_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic sit_pkg::rsp_t mk_rsp(input logic [1:0] st, input int cnt,
                                           input logic signed [31:0] s,
                                           input logic signed [31:0] e,
                                           input logic [15:0] id, input int pos,
                                           input logic lst);
    sit_pkg::rsp_t r;
    r.status = st;
    r.count = cnt[sit_pkg::CNT_W-1:0];
    r.entry_start = s;
    r.entry_end = e;
    r.entry_id = id;
    r.position = pos[sit_pkg::POS_W-1:0];
    r.last = lst;
    return r;
  endfunction

  function automatic sit_pkg::req_t mk_req(input logic [2:0] cmd,
                                           input logic signed [31:0] lo,
                                           input logic signed [31:0] hi,
                                           input logic [15:0] id, input logic mv);
    sit_pkg::req_t r;
    r.command = cmd;
    r.range_start = lo;
    r.range_end = hi;
    r.node_id = id;
    r.move_overlapping = mv;
    return r;
  endfunction

  // append one expected result
  task automatic queue_rsp(input sit_pkg::rsp_t r);
    pending_rsp.insert(pending_rsp.size(), r);
  endtask

  // append one directed row
  task automatic add_row(input sit_pkg::req_t r, input bit typed, input sit_pkg::rsp_t rsp);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.rsp = rsp;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // stable sort by start then overlap walk; track follows one slot
  task automatic repair_shadow(inout int track);
    logic signed [31:0] ks, ke, prev, ns;
    logic [15:0] kid;
    longint dur;
    bit tracked;
    int j;
    for (int i = 1; i < shadow_count; i++) begin
      ks = shadow_start[i];
      ke = shadow_end[i];
      kid = shadow_id[i];
      tracked = (track == i);
      j = i;
      while (j > 0 && shadow_start[j-1] > ks) begin
        shadow_start[j] = shadow_start[j-1];
        shadow_end[j] = shadow_end[j-1];
        shadow_id[j] = shadow_id[j-1];
        if (track == j - 1) track = j;
        j--;
      end
      shadow_start[j] = ks;
      shadow_end[j] = ke;
      shadow_id[j] = kid;
      if (tracked) track = j;
    end
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] < 0) begin
        shadow_end[i] = clamp32(longint'(shadow_end[i]) - longint'(shadow_start[i]));
        shadow_start[i] = 0;
      end
      prev = shadow_end[i];
      if (i + 1 < shadow_count && shadow_start[i+1] < prev) begin
        dur = longint'(shadow_end[i+1]) - longint'(shadow_start[i+1]);
        ns = clamp32(longint'(prev) + 1);
        shadow_start[i+1] = ns;
        shadow_end[i+1] = clamp32(longint'(ns) + dur);
      end
    end
  endtask

  // apply one request to the shadow table and queue the results it gives
  task automatic predict_table(input sit_pkg::req_t r);
    int pos, kept, hits, none;
    bit found;
    case (r.command)
      sit_pkg::CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          queue_rsp(mk_rsp(sit_pkg::ST_FULL, shadow_count, 0, 0, 16'h0, 0, 1'b1));
        end else begin
          pos = 0;
          for (int i = 0; i < shadow_count; i++)
            if (shadow_start[i] <= r.range_start) pos = i + 1;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_start[i] = shadow_start[i-1];
            shadow_end[i] = shadow_end[i-1];
            shadow_id[i] = shadow_id[i-1];
          end
          shadow_start[pos] = r.range_start;
          shadow_end[pos] = r.range_end;
          shadow_id[pos] = r.node_id;
          shadow_count++;
          if (r.move_overlapping) repair_shadow(pos);
          queue_rsp(mk_rsp(sit_pkg::ST_OK, shadow_count, shadow_start[pos],
                           shadow_end[pos], shadow_id[pos], pos, 1'b1));
        end
      end
      sit_pkg::CMD_DELETE: begin
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (!(shadow_start[i] >= r.range_start && shadow_end[i] <= r.range_end)) begin
            shadow_start[kept] = shadow_start[i];
            shadow_end[kept] = shadow_end[i];
            shadow_id[kept] = shadow_id[i];
            kept++;
          end
        end
        queue_rsp(mk_rsp((shadow_count != kept) ? sit_pkg::ST_OK : sit_pkg::ST_NONE,
                         shadow_count - kept, 0, 0, 16'h0, 0, 1'b1));
        shadow_count = kept;
      end
      sit_pkg::CMD_FIND: begin
        found = 1'b0;
        for (int i = 0; i < shadow_count && !found; i++) begin
          if (shadow_id[i] == r.node_id) begin
            found = 1'b1;
            queue_rsp(mk_rsp(sit_pkg::ST_OK, shadow_count, shadow_start[i],
                             shadow_end[i], shadow_id[i], i, 1'b1));
          end
        end
        if (!found) queue_rsp(mk_rsp(sit_pkg::ST_NONE, shadow_count, 0, 0, 16'h0, 0, 1'b1));
      end
      sit_pkg::CMD_QUERY: begin
        hits = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_start[i] >= r.range_start && shadow_end[i] <= r.range_end) begin
            queue_rsp(mk_rsp(sit_pkg::ST_OK, shadow_count, shadow_start[i],
                             shadow_end[i], shadow_id[i], i, 1'b0));
            hits++;
          end
        end
        if (hits == 0) queue_rsp(mk_rsp(sit_pkg::ST_NONE, shadow_count, 0, 0, 16'h0, 0, 1'b1));
        else pending_rsp[$].last = 1'b1;
      end
      default: begin
        // repair alone, and unknown codes which leave the table untouched
        if (r.command == sit_pkg::CMD_REPAIR) begin
          none = DEPTH;
          repair_shadow(none);
        end
        queue_rsp(mk_rsp(sit_pkg::ST_OK, shadow_count, 0, 0, 16'h0, 0, 1'b1));
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    sit_pkg::rsp_t want;
    if (!rst && strobe) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = pending_rsp.pop_front();
        if (result.status !== want.status || result.count !== want.count ||
            result.entry_start !== want.entry_start || result.entry_end !== want.entry_end ||
            result.entry_id !== want.entry_id || result.position !== want.position ||
            result.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, result);
        end
      end
    end
  end

  // present one request and hold it until taken; start then stays high unless a random idle gap follows
  task automatic send_request(input sit_pkg::req_t r, input bit typed,
                              input sit_pkg::rsp_t typed_rsp);
    int gap;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    predict_table(r);
    if (typed) begin
      void'(pending_rsp.pop_back());
      queue_rsp(typed_rsp);
    end
    gap = $urandom_range(0, 9);
    if (gap < 6) gap = 0;
    else if (gap < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $signed($urandom_range(0, 600)) - 100;
    if (sel < 9) return $urandom;
    return (sel[0] ^ $urandom_range(0, 1)) ? 32'sh7fff_ffff - $urandom_range(0, 20)
                                           : 32'sh8000_0000 + $urandom_range(0, 20);
  endfunction

  function automatic sit_pkg::req_t random_request();
    sit_pkg::req_t r;
    int sel;
    logic signed [31:0] a, b;
    sel = $urandom_range(0, 99);
    a = pick_value();
    b = ($urandom_range(0, 9) < 8) ? clamp32(longint'(a) + $urandom_range(0, 80)) : pick_value();
    if (sel < 40 && shadow_count < 50) r.command = sit_pkg::CMD_INSERT;
    else if (sel < 40) r.command = sit_pkg::CMD_DELETE;
    else if (sel < 50) r.command = sit_pkg::CMD_REPAIR;
    else if (sel < 60) r.command = sit_pkg::CMD_DELETE;
    else if (sel < 77) r.command = sit_pkg::CMD_FIND;
    else if (sel < 95) r.command = sit_pkg::CMD_QUERY;
    else r.command = 3'($urandom_range(5, 7));
    r.range_start = a;
    r.range_end = b;
    r.node_id = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    r.move_overlapping = 1'($urandom_range(0, 1));
    // a wide delete now and then keeps the table from sitting full
    if (r.command == sit_pkg::CMD_DELETE && $urandom_range(0, 3) == 0) begin
      r.range_start = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sd0;
      r.range_end = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  initial begin
    mismatches = 0;
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sit_pkg::rsp_t blank;

    blank = '0;
    shadow_count = 0;
    start = 1'b0;
    request = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: empty table, extremes, equal starts, negative shift, saturation
    add_row(mk_req(sit_pkg::CMD_FIND, 0, 0, 16'h0000, 1'b0), 1'b1,
            mk_rsp(sit_pkg::ST_NONE, 0, 0, 0, 16'h0, 0, 1'b1));
    add_row(mk_req(sit_pkg::CMD_QUERY, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0), 1'b1,
            mk_rsp(sit_pkg::ST_NONE, 0, 0, 0, 16'h0, 0, 1'b1));
    add_row(mk_req(sit_pkg::CMD_REPAIR, 0, 0, 16'h0, 1'b0), 1'b1,
            mk_rsp(sit_pkg::ST_OK, 0, 0, 0, 16'h0, 0, 1'b1));
    add_row(mk_req(sit_pkg::CMD_DELETE, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0), 1'b1,
            mk_rsp(sit_pkg::ST_NONE, 0, 0, 0, 16'h0, 0, 1'b1));
    add_row(mk_req(3'd7, 5, 9, 16'hffff, 1'b1), 1'b1,
            mk_rsp(sit_pkg::ST_OK, 0, 0, 0, 16'h0, 0, 1'b1));
    add_row(mk_req(sit_pkg::CMD_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 16'hffff, 1'b0), 1'b1,
            mk_rsp(sit_pkg::ST_OK, 1, 32'sh8000_0000, 32'sh7fff_ffff, 16'hffff, 0, 1'b1));
    add_row(mk_req(sit_pkg::CMD_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 16'h0000, 1'b0),
            1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, 10, 20, 16'h0001, 1'b0), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, 10, 30, 16'h0002, 1'b0), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, 15, 12, 16'h0003, 1'b1), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_FIND, 0, 0, 16'hffff, 1'b0), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_FIND, 0, 0, 16'h1234, 1'b0), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_QUERY, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0),
            1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_QUERY, 0, 0, 16'h0, 1'b0), 1'b0, blank);
    add_row(mk_req(3'd5, 0, 0, 16'h0, 1'b0), 1'b0, blank);
    add_row(mk_req(3'd6, 0, 0, 16'h0, 1'b1), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_DELETE, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0),
            1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, -50, -10, 16'h0010, 1'b1), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, 32'sh7fff_fff0, 32'sh7fff_fffe, 16'h0011, 1'b1),
            1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_INSERT, 32'sh7fff_fff0, 32'sh7fff_fffe, 16'h0012, 1'b1),
            1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_REPAIR, 0, 0, 16'h0, 1'b0), 1'b0, blank);
    add_row(mk_req(sit_pkg::CMD_QUERY, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0),
            1'b0, blank);
    foreach (stim_rows[k]) send_request(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].rsp);

    // fill the table, then one more insert must report full
    while (shadow_count < DEPTH)
      send_request(mk_req(sit_pkg::CMD_INSERT, pick_value(), pick_value(), 16'($urandom), 1'b0),
                   1'b0, blank);
    send_request(mk_req(sit_pkg::CMD_INSERT, 1, 2, 16'h0abc, 1'b1), 1'b1,
                 mk_rsp(sit_pkg::ST_FULL, DEPTH, 0, 0, 16'h0, 0, 1'b1));
    send_request(mk_req(sit_pkg::CMD_QUERY, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0),
                 1'b0, blank);
    send_request(mk_req(sit_pkg::CMD_REPAIR, 0, 0, 16'h0, 1'b0), 1'b0, blank);
    send_request(mk_req(sit_pkg::CMD_DELETE, 32'sh8000_0000, 32'sh7fff_ffff, 16'h0, 1'b0),
                 1'b0, blank);

    // random requests, with one full drain half way
    for (int k = 0; k < 380; k++) begin
      if (k == 190) begin
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_request(random_request(), 1'b0, blank);
    end

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
